>>> sv/latin_square_hop_chain_macros.svh
// Assertion macros used by lshc_ctrl.
`ifndef LATIN_SQUARE_HOP_CHAIN_MACROS_SVH
`define LATIN_SQUARE_HOP_CHAIN_MACROS_SVH

// Condition in a cycle implies consequence in the same cycle.
`define LSHC_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Condition in a cycle implies consequence in the next cycle.
`define LSHC_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lshc_pkg.sv
`default_nettype none
package lshc_pkg;

   localparam int MAX_ORDER_DEFAULT = 16;
   localparam logic [4:0] ORDER_RESET = 5'd16;

   typedef enum logic [1:0] {
      ACT_HOP  = 2'd0,
      ACT_READ = 2'd1,
      ACT_LOAD = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_RC_SET_S  = 3'd0,
      ST_XY_TEST_Z = 3'd1,
      ST_RY_SET_Z  = 3'd2,
      ST_XC_SET_Z  = 3'd3,
      ST_XY_SET_S  = 3'd4,
      ST_RC_CLR_Z  = 3'd5,
      ST_RY_CLR_S  = 3'd6,
      ST_XC_CLR_S  = 3'd7
   } step_type;

endpackage
`default_nettype wire

>>> sv/lshc_cube_mem.sv
`default_nettype none
module lshc_cube_mem
   import lshc_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT,
   parameter int AW = $clog2(MAX_ORDER * MAX_ORDER)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [MAX_ORDER-1:0] wdata,
   input  wire logic [AW-1:0]        raddr,
   output logic      [MAX_ORDER-1:0] rdata
);

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;

   logic [MAX_ORDER-1:0] mem [DEPTH];
   logic [MAX_ORDER-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> sv/lshc_ctrl.sv
`default_nettype none
module lshc_ctrl
   import lshc_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT,
   parameter int NW = $clog2(MAX_ORDER + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [NW-1:0] n,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_action,
   input  wire logic [3:0]    req_row,
   input  wire logic [3:0]    req_col,
   input  wire logic [3:0]    req_symbol,
   input  wire logic          req_pick_row,
   input  wire logic          req_pick_col,
   input  wire logic          req_pick_symbol,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_improper_now,
   output logic               rsp_null_move,
   output logic [3:0]         rsp_far_row,
   output logic [3:0]         rsp_far_col,
   output logic [3:0]         rsp_far_symbol,
   output logic [15:0]        rsp_cell_mask
);

`include "latin_square_hop_chain_macros.svh"

   localparam int MW = MAX_ORDER;
   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
   localparam int CW = NW + 8;
   localparam int N_RST = (MAX_ORDER < int'(ORDER_RESET)) ? MAX_ORDER : int'(ORDER_RESET);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SWEEP  = 10'b0000000010,
      S_CELL   = 10'b0000000100,
      S_CELLW  = 10'b0000001000,
      S_SCAN   = 10'b0000010000,
      S_SCANW  = 10'b0000100000,
      S_PICK   = 10'b0001000000,
      S_RMW_RD = 10'b0010000000,
      S_RMW_WR = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic          we;
      logic [AW-1:0] waddr;
      logic [MW-1:0] wdata;
      logic [AW-1:0] raddr;
   } mem_port_type;

   state_type     state_ff, state_in;
   step_type      step_ff, step_in;
   action_type    act_ff, act_in;
   logic [NW-1:0] n_ff, n_in;
   logic [IW-1:0] r_ff, r_in, c_ff, c_in, s_ff, s_in;
   logic [IW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [IW-1:0] neg_r_ff, neg_r_in, neg_c_ff, neg_c_in, neg_s_ff, neg_s_in;
   logic [IW-1:0] idx_ff, idx_in, cap_idx_ff, cap_idx_in;
   logic [IW-1:0] si_ff, si_in, sj_ff, sj_in;
   logic [2:0]    pk_ff, pk_in;
   logic          imp_ff, imp_in, hop_imp_ff, hop_imp_in;
   logic          ph_ff, ph_in, cap_v_ff, cap_v_in, cap_ph_ff, cap_ph_in;
   logic          sweep_item_ff, sweep_item_in;
   logic [MW-1:0] zm_ff, zm_in, ym_ff, ym_in, xm_ff, xm_in;
   logic          res_null_ff, res_null_in, res_ok_ff, res_ok_in;
   logic [15:0]   res_mask_ff, res_mask_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_imp_ff, rsp_imp_in;
   logic          rsp_null_ff, rsp_null_in;
   logic [3:0]    rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in, rsp_sym_ff, rsp_sym_in;
   logic [15:0]   rsp_mask_ff, rsp_mask_in;

   mem_port_type  mem;
   logic [MW-1:0] rd;
   logic [MW-1:0] lim;
   logic [IW:0]   sum;
   logic [IW-1:0] sym;
   logic [IW-1:0] st_r, st_c, st_b;
   logic          st_set;
   logic [MW-1:0] st_bit;

   function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_ORDER) + AW'(c));
   endfunction

   function automatic logic [IW-1:0] choose(logic [MW-1:0] m, logic hi);
      logic [IW-1:0] found;
      logic          seen;
      found = '0;
      seen = 1'b0;
      for (int i = 0; i < MW; i++) begin
         if (m[i] && (hi || !seen)) begin
            found = IW'(i);
            seen = 1'b1;
         end
      end
      return found;
   endfunction

   lshc_cube_mem #(
      .MAX_ORDER(MAX_ORDER),
      .AW(AW)
   ) u_mem (
      .clock(clock),
      .we(mem.we),
      .waddr(mem.waddr),
      .wdata(mem.wdata),
      .raddr(mem.raddr),
      .rdata(rd)
   );

   always_comb begin
      for (int i = 0; i < MW; i++) begin
         lim[i] = (CW'(i) < CW'(n));
      end
   end

   always_comb begin
      sum = (IW + 1)'(si_ff) + (IW + 1)'(sj_ff);
      if (CW'(sum) >= CW'(n_ff)) begin
         sum = (IW + 1)'(CW'(sum) - CW'(n_ff));
      end
      sym = IW'(sum);
   end

   always_comb begin
      st_r = r_ff;
      st_c = c_ff;
      st_b = s_ff;
      st_set = 1'b1;
      unique case (step_ff)
         ST_RC_SET_S: begin
            st_r = r_ff; st_c = c_ff; st_b = s_ff; st_set = 1'b1;
         end
         ST_XY_TEST_Z: begin
            st_r = x_ff; st_c = y_ff; st_b = z_ff; st_set = 1'b0;
         end
         ST_RY_SET_Z: begin
            st_r = r_ff; st_c = y_ff; st_b = z_ff; st_set = 1'b1;
         end
         ST_XC_SET_Z: begin
            st_r = x_ff; st_c = c_ff; st_b = z_ff; st_set = 1'b1;
         end
         ST_XY_SET_S: begin
            st_r = x_ff; st_c = y_ff; st_b = s_ff; st_set = 1'b1;
         end
         ST_RC_CLR_Z: begin
            st_r = r_ff; st_c = c_ff; st_b = z_ff; st_set = 1'b0;
         end
         ST_RY_CLR_S: begin
            st_r = r_ff; st_c = y_ff; st_b = s_ff; st_set = 1'b0;
         end
         ST_XC_CLR_S: begin
            st_r = x_ff; st_c = c_ff; st_b = s_ff; st_set = 1'b0;
         end
         default: begin
            st_set = 1'b0;
         end
      endcase
      st_bit = MW'(1) << st_b;
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      act_in = act_ff;
      n_in = n_ff;
      r_in = r_ff; c_in = c_ff; s_in = s_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      neg_r_in = neg_r_ff; neg_c_in = neg_c_ff; neg_s_in = neg_s_ff;
      idx_in = idx_ff;
      cap_idx_in = idx_ff;
      cap_ph_in = ph_ff;
      cap_v_in = 1'b0;
      si_in = si_ff; sj_in = sj_ff;
      pk_in = pk_ff;
      imp_in = imp_ff;
      hop_imp_in = hop_imp_ff;
      ph_in = ph_ff;
      sweep_item_in = sweep_item_ff;
      zm_in = zm_ff; ym_in = ym_ff; xm_in = xm_ff;
      res_null_in = res_null_ff;
      res_ok_in = res_ok_ff;
      res_mask_in = res_mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_imp_in = rsp_imp_ff;
      rsp_null_in = rsp_null_ff;
      rsp_row_in = rsp_row_ff; rsp_col_in = rsp_col_ff; rsp_sym_in = rsp_sym_ff;
      rsp_mask_in = rsp_mask_ff;
      mem.we = 1'b0;
      mem.waddr = addr_of(st_r, st_c);
      mem.wdata = rd;
      mem.raddr = addr_of(r_ff, c_ff);

      if (cap_v_ff && rd[s_ff]) begin
         if (cap_ph_ff) begin
            xm_in[cap_idx_ff] = 1'b1;
         end else begin
            ym_in[cap_idx_ff] = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = action_type'(req_action);
               pk_in = {req_pick_row, req_pick_col, req_pick_symbol};
               hop_imp_in = imp_ff;
               res_null_in = 1'b0;
               res_ok_in = 1'b0;
               res_mask_in = '0;
               state_in = S_DONE;
               unique case (action_type'(req_action))
                  ACT_LOAD: begin
                     si_in = '0;
                     sj_in = '0;
                     n_in = n;
                     sweep_item_in = 1'b1;
                     state_in = S_SWEEP;
                  end
                  ACT_READ: begin
                     r_in = IW'(req_row);
                     c_in = IW'(req_col);
                     if (CW'(req_row) < CW'(n) && CW'(req_col) < CW'(n)) begin
                        state_in = S_CELL;
                     end
                  end
                  ACT_HOP: begin
                     if (imp_ff) begin
                        r_in = neg_r_ff; c_in = neg_c_ff; s_in = neg_s_ff;
                        if (CW'(neg_r_ff) < CW'(n) && CW'(neg_c_ff) < CW'(n)
                            && CW'(neg_s_ff) < CW'(n)) begin
                           state_in = S_CELL;
                        end else begin
                           res_null_in = 1'b1;
                        end
                     end else begin
                        r_in = IW'(req_row); c_in = IW'(req_col); s_in = IW'(req_symbol);
                        if (CW'(req_row) < CW'(n) && CW'(req_col) < CW'(n)
                            && CW'(req_symbol) < CW'(n)) begin
                           state_in = S_CELL;
                        end else begin
                           res_null_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            mem.we = 1'b1;
            mem.waddr = addr_of(si_ff, sj_ff);
            mem.wdata = (CW'(si_ff) < CW'(n_ff) && CW'(sj_ff) < CW'(n_ff))
                        ? (MW'(1) << sym) : '0;
            sj_in = sj_ff + IW'(1);
            if (sj_ff == IW'(MAX_ORDER - 1)) begin
               sj_in = '0;
               si_in = si_ff + IW'(1);
               if (si_ff == IW'(MAX_ORDER - 1)) begin
                  si_in = '0;
                  imp_in = 1'b0;
                  neg_r_in = '0; neg_c_in = '0; neg_s_in = '0;
                  state_in = sweep_item_ff ? S_DONE : S_IDLE;
               end
            end
         end
         S_CELL: begin
            mem.raddr = addr_of(r_ff, c_ff);
            state_in = S_CELLW;
         end
         S_CELLW: begin
            if (act_ff == ACT_READ) begin
               res_mask_in = 16'(rd & lim);
               state_in = S_DONE;
            end else if (rd[s_ff]) begin
               res_null_in = 1'b1;
               state_in = S_DONE;
            end else begin
               zm_in = rd & lim;
               ym_in = '0;
               xm_in = '0;
               ph_in = 1'b0;
               idx_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            mem.raddr = ph_ff ? addr_of(idx_ff, c_ff) : addr_of(r_ff, idx_ff);
            cap_v_in = 1'b1;
            idx_in = idx_ff + IW'(1);
            if (CW'(idx_ff) + CW'(1) == CW'(n)) begin
               idx_in = '0;
               ph_in = 1'b1;
               if (ph_ff) begin
                  state_in = S_SCANW;
               end
            end
         end
         S_SCANW: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (zm_ff == '0 || ym_ff == '0 || xm_ff == '0) begin
               res_null_in = 1'b1;
               state_in = S_DONE;
            end else begin
               x_in = choose(xm_ff, pk_ff[2]);
               y_in = choose(ym_ff, pk_ff[1]);
               z_in = choose(zm_ff, pk_ff[0]);
               step_in = hop_imp_ff ? ST_XY_TEST_Z : ST_RC_SET_S;
               state_in = S_RMW_RD;
            end
         end
         S_RMW_RD: begin
            mem.raddr = addr_of(st_r, st_c);
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem.we = 1'b1;
            mem.wdata = st_set ? (rd | st_bit) : (rd & ~st_bit);
            if (step_ff == ST_XY_TEST_Z) begin
               if (rd[z_ff]) begin
                  imp_in = 1'b0;
               end else begin
                  imp_in = 1'b1;
                  neg_r_in = x_ff; neg_c_in = y_ff; neg_s_in = z_ff;
               end
            end
            if (step_ff == ST_XC_CLR_S) begin
               res_ok_in = 1'b1;
               state_in = S_DONE;
            end else begin
               step_in = step_type'(step_ff + 3'd1);
               state_in = S_RMW_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_imp_in = imp_ff;
               rsp_null_in = res_null_ff;
               rsp_row_in = res_ok_ff ? 4'(x_ff) : 4'd0;
               rsp_col_in = res_ok_ff ? 4'(y_ff) : 4'd0;
               rsp_sym_in = res_ok_ff ? 4'(z_ff) : 4'd0;
               rsp_mask_in = res_mask_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         n_ff <= NW'(N_RST);
         si_ff <= '0;
         sj_ff <= '0;
         sweep_item_ff <= 1'b0;
         imp_ff <= 1'b0;
         neg_r_ff <= '0;
         neg_c_ff <= '0;
         neg_s_ff <= '0;
         cap_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         si_ff <= si_in;
         sj_ff <= sj_in;
         sweep_item_ff <= sweep_item_in;
         imp_ff <= imp_in;
         neg_r_ff <= neg_r_in;
         neg_c_ff <= neg_c_in;
         neg_s_ff <= neg_s_in;
         cap_v_ff <= cap_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      act_ff <= act_in;
      r_ff <= r_in; c_ff <= c_in; s_ff <= s_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      idx_ff <= idx_in;
      cap_idx_ff <= cap_idx_in;
      cap_ph_ff <= cap_ph_in;
      pk_ff <= pk_in;
      hop_imp_ff <= hop_imp_in;
      ph_ff <= ph_in;
      zm_ff <= zm_in; ym_ff <= ym_in; xm_ff <= xm_in;
      res_null_ff <= res_null_in;
      res_ok_ff <= res_ok_in;
      res_mask_ff <= res_mask_in;
      rsp_imp_ff <= rsp_imp_in;
      rsp_null_ff <= rsp_null_in;
      rsp_row_ff <= rsp_row_in; rsp_col_ff <= rsp_col_in; rsp_sym_ff <= rsp_sym_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_improper_now = rsp_imp_ff;
   assign rsp_null_move = rsp_null_ff;
   assign rsp_far_row = rsp_row_ff;
   assign rsp_far_col = rsp_col_ff;
   assign rsp_far_symbol = rsp_sym_ff;
   assign rsp_cell_mask = rsp_mask_ff;

   `LSHC_ASSERT_NOW(a_no_write_in_scan, state_ff == S_SCAN || state_ff == S_CELLW, !mem.we,
      "cube written during a scan")
   `LSHC_ASSERT_NOW(a_imp_rise_src, $rose(imp_ff), $past(state_ff == S_RMW_WR),
      "improper flag set outside the test step")
   `LSHC_ASSERT_NEXT(a_rd_then_wr, state_ff == S_RMW_RD, state_ff == S_RMW_WR,
      "read-modify-write step broken")
   `LSHC_ASSERT_NOW(a_null_no_far, rsp_valid_ff && rsp_null_ff,
      rsp_row_ff == 4'd0 && rsp_col_ff == 4'd0 && rsp_sym_ff == 4'd0,
      "null move reports a far triple")

endmodule
`default_nettype wire

>>> sv/latin_square_hop_chain.sv
// Channel   Ports                                  Direction
// req       req_valid, req_stall, req_* fields     in
// rsp       rsp_valid, rsp_stall, rsp_* fields     out
// csr       csr_we, csr_wdata (order)              in
// A hop is paced by the memory's one read port, which serves both the scan and the
// read-modify-writes; from an improper square it skips the first read-modify-write.
// A load, and the pass after reset, write MAX_ORDER * MAX_ORDER cells, one per cycle.
// No item is accepted during that pass after reset; reset is synchronous.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
module latin_square_hop_chain
   import lshc_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_row,
   input  wire logic [3:0]  req_col,
   input  wire logic [3:0]  req_symbol,
   input  wire logic        req_pick_row,
   input  wire logic        req_pick_col,
   input  wire logic        req_pick_symbol,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_improper_now,
   output logic             rsp_null_move,
   output logic [3:0]       rsp_far_row,
   output logic [3:0]       rsp_far_col,
   output logic [3:0]       rsp_far_symbol,
   output logic [15:0]      rsp_cell_mask
);

   localparam int NW = $clog2(MAX_ORDER + 1);

   logic [4:0]    order_ff, order_in;
   logic [NW-1:0] n_eff;

   always_comb begin
      order_in = csr_we ? csr_wdata : order_ff;
      if (order_ff < 5'd2) begin
         n_eff = NW'(2);
      end else if (int'(order_ff) > MAX_ORDER) begin
         n_eff = NW'(MAX_ORDER);
      end else begin
         n_eff = NW'(order_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else begin
         order_ff <= order_in;
      end
   end

   lshc_ctrl #(
      .MAX_ORDER(MAX_ORDER),
      .NW(NW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .n(n_eff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_row(req_row),
      .req_col(req_col),
      .req_symbol(req_symbol),
      .req_pick_row(req_pick_row),
      .req_pick_col(req_pick_col),
      .req_pick_symbol(req_pick_symbol),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_improper_now(rsp_improper_now),
      .rsp_null_move(rsp_null_move),
      .rsp_far_row(rsp_far_row),
      .rsp_far_col(rsp_far_col),
      .rsp_far_symbol(rsp_far_symbol),
      .rsp_cell_mask(rsp_cell_mask)
   );

endmodule
`default_nettype wire

>>> test/latin_square_hop_chain_tb.sv
`default_nettype none
module latin_square_hop_chain_tb;
   import lshc_pkg::*;

   typedef struct packed {
      logic        improper_now;
      logic        null_move;
      logic [3:0]  far_row;
      logic [3:0]  far_col;
      logic [3:0]  far_symbol;
      logic [15:0] cell_mask;
   } hop_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [3:0]  req_row = '0;
   logic [3:0]  req_col = '0;
   logic [3:0]  req_symbol = '0;
   logic        req_pick_row = 1'b0;
   logic        req_pick_col = 1'b0;
   logic        req_pick_symbol = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_improper_now;
   logic        rsp_null_move;
   logic [3:0]  rsp_far_row;
   logic [3:0]  rsp_far_col;
   logic [3:0]  rsp_far_symbol;
   logic [15:0] rsp_cell_mask;

   // Shadow copy of the incidence cube and the chain state.
   logic [15:0] square_masks [16][16];
   logic [3:0]  neg_row, neg_col, neg_symbol;
   logic        square_improper;
   logic [4:0]  order_reg;

   hop_result_type pending_results [$];
   int          failures = 0;
   int          gap_limit = 0;
   int          stall_limit = 0;
   int          long_hold = 0;

   latin_square_hop_chain uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_row(req_row), .req_col(req_col), .req_symbol(req_symbol),
      .req_pick_row(req_pick_row), .req_pick_col(req_pick_col),
      .req_pick_symbol(req_pick_symbol), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_improper_now(rsp_improper_now), .rsp_null_move(rsp_null_move),
      .rsp_far_row(rsp_far_row), .rsp_far_col(rsp_far_col),
      .rsp_far_symbol(rsp_far_symbol), .rsp_cell_mask(rsp_cell_mask)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int side_length();
      if (order_reg < 2) return 2;
      if (order_reg > 16) return 16;
      return int'(order_reg);
   endfunction

   function automatic logic [3:0] pick_index(logic [15:0] m, logic largest);
      logic [3:0] found;
      found = '0;
      for (int i = 0; i < 16; i++) begin
         if (m[i]) begin
            found = 4'(i);
            if (!largest) return found;
         end
      end
      return found;
   endfunction

   task automatic load_cyclic_square();
      int n;
      n = side_length();
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 16; j++) begin
            square_masks[i][j] = (i < n && j < n) ? 16'(1) << ((i + j) % n) : '0;
         end
      end
      neg_row = '0;
      neg_col = '0;
      neg_symbol = '0;
      square_improper = 1'b0;
   endtask

   task automatic predict_hop_chain(action_type a, logic [3:0] r_in, logic [3:0] c_in,
         logic [3:0] s_in, logic pr, logic pc, logic ps);
      hop_result_type res;
      int n;
      logic [15:0] lim, zm, ym, xm;
      logic [3:0] r, c, s, x, y, z;
      res = '0;
      n = side_length();
      lim = (n >= 16) ? 16'hFFFF : ((16'(1) << n) - 16'(1));
      ym = '0;
      xm = '0;
      if (a == ACT_LOAD) begin
         load_cyclic_square();
      end else if (a == ACT_READ) begin
         if (r_in < n && c_in < n) res.cell_mask = square_masks[r_in][c_in] & lim;
      end else if (a == ACT_HOP) begin
         if (square_improper) begin
            r = neg_row; c = neg_col; s = neg_symbol;
         end else begin
            r = r_in; c = c_in; s = s_in;
         end
         if (r >= n || c >= n || s >= n || square_masks[r][c][s]) begin
            res.null_move = 1'b1;
         end else begin
            zm = square_masks[r][c] & lim;
            for (int i = 0; i < n; i++) begin
               ym[i] = square_masks[r][i][s];
               xm[i] = square_masks[i][c][s];
            end
            if (zm == 0 || ym == 0 || xm == 0) begin
               res.null_move = 1'b1;
            end else begin
               x = pick_index(xm, pr);
               y = pick_index(ym, pc);
               z = pick_index(zm, ps);
               if (!square_improper) square_masks[r][c][s] = 1'b1;
               if (square_masks[x][y][z]) begin
                  square_masks[x][y][z] = 1'b0;
                  square_improper = 1'b0;
               end else begin
                  neg_row = x; neg_col = y; neg_symbol = z;
                  square_improper = 1'b1;
               end
               square_masks[r][y][z] = 1'b1;
               square_masks[x][c][z] = 1'b1;
               square_masks[x][y][s] = 1'b1;
               square_masks[r][c][z] = 1'b0;
               square_masks[r][y][s] = 1'b0;
               square_masks[x][c][s] = 1'b0;
               res.far_row = x;
               res.far_col = y;
               res.far_symbol = z;
            end
         end
      end
      res.improper_now = square_improper;
      pending_results = {pending_results, res};
   endtask

   task automatic send_item(action_type a, logic [3:0] r, logic [3:0] c, logic [3:0] s,
         logic pr, logic pc, logic ps);
      int gap;
      gap = (gap_limit > 0) ? int'($urandom_range(gap_limit, 0)) : 0;
      repeat (gap) @(negedge clock);
      req_action = a;
      req_row = r;
      req_col = c;
      req_symbol = s;
      req_pick_row = pr;
      req_pick_col = pc;
      req_pick_symbol = ps;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_hop_chain(a, r, c, s, pr, pc, ps);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_order(logic [4:0] value);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      order_reg = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_random_item();
      int n, sel;
      logic [3:0] r, c, s;
      n = side_length();
      sel = int'($urandom_range(99, 0));
      r = 4'($urandom_range(n - 1, 0));
      c = 4'($urandom_range(n - 1, 0));
      s = 4'($urandom_range(n - 1, 0));
      if (sel < 8) begin
         r = 4'($urandom);
         c = 4'($urandom);
         s = 4'($urandom);
      end
      if (sel < 75) begin
         send_item(ACT_HOP, r, c, s, 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (sel < 92) begin
         send_item(ACT_READ, r, c, 4'($urandom), 1'($urandom), 1'($urandom),
            1'($urandom));
      end else if (sel < 97) begin
         send_item(ACT_LOAD, 4'($urandom), 4'($urandom), 4'($urandom), 1'($urandom),
            1'($urandom), 1'($urandom));
      end else begin
         send_item(ACT_NONE, r, c, s, 1'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_reset_square();
      send_item(ACT_READ, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_READ, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1, 1'b1);
      send_item(ACT_READ, 4'd15, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_NONE, 4'd3, 4'd5, 4'd7, 1'b1, 1'b0, 1'b1);
      send_item(ACT_HOP, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd15, 4'd15, 4'd0, 1'b1, 1'b1, 1'b1);
      send_item(ACT_HOP, 4'd1, 4'd2, 4'd9, 1'b0, 1'b1, 1'b0);
   endtask

   task automatic test_small_square();
      write_order(5'd4);
      send_item(ACT_LOAD, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd5, 4'd0, 4'd1, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd0, 4'd0, 4'd4, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd0, 4'd0, 4'd1, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd0, 4'd0, 4'd0, 1'b1, 1'b1, 1'b1);
      send_item(ACT_HOP, 4'd2, 4'd3, 4'd3, 1'b1, 1'b0, 1'b1);
      send_item(ACT_READ, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_READ, 4'd3, 4'd3, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_READ, 4'd4, 4'd1, 4'd0, 1'b0, 1'b0, 1'b0);
      write_order(5'd3);
      send_item(ACT_HOP, 4'd0, 4'd0, 4'd2, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd1, 4'd1, 4'd0, 1'b1, 1'b1, 1'b0);
      write_order(5'd1);
      send_item(ACT_LOAD, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_HOP, 4'd0, 4'd1, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_READ, 4'd1, 4'd1, 4'd0, 1'b0, 1'b0, 1'b0);
      write_order(5'd31);
      send_item(ACT_READ, 4'd15, 4'd15, 4'd0, 1'b0, 1'b0, 1'b0);
      send_item(ACT_LOAD, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_random_walks();
      logic [4:0] orders [8] = '{5'd2, 5'd3, 5'd5, 5'd7, 5'd16, 5'd0, 5'd9, 5'd31};
      for (int p = 0; p < 8; p++) begin
         write_order(orders[p]);
         gap_limit = (p % 3 == 0) ? 0 : 15;
         stall_limit = (p % 4 == 1) ? 0 : 15;
         if (p % 2 == 0) send_item(ACT_LOAD, '0, '0, '0, 1'b0, 1'b0, 1'b0);
         repeat (70) send_random_item();
      end
      gap_limit = 15;
      stall_limit = 15;
   endtask

   task automatic test_backpressure();
      write_order(5'd6);
      gap_limit = 0;
      long_hold = 400;
      repeat (30) send_random_item();
      wait_drained();
      repeat (20) send_random_item();
      gap_limit = 15;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_stall = 1'b1;
            repeat (long_hold) @(negedge clock);
            long_hold = 0;
         end
         if (stall_limit > 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(stall_limit, 0)) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && long_hold == 0);
      end
   end

   always @(posedge clock) begin
      hop_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation pending");
            failures++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_improper_now !== exp_res.improper_now) begin
               $error("improper_now expected %0d actual %0d", exp_res.improper_now,
                  rsp_improper_now);
               failures++;
            end
            if (rsp_null_move !== exp_res.null_move) begin
               $error("null_move expected %0d actual %0d", exp_res.null_move, rsp_null_move);
               failures++;
            end
            if (rsp_far_row !== exp_res.far_row) begin
               $error("far_row expected %0d actual %0d", exp_res.far_row, rsp_far_row);
               failures++;
            end
            if (rsp_far_col !== exp_res.far_col) begin
               $error("far_col expected %0d actual %0d", exp_res.far_col, rsp_far_col);
               failures++;
            end
            if (rsp_far_symbol !== exp_res.far_symbol) begin
               $error("far_symbol expected %0d actual %0d", exp_res.far_symbol,
                  rsp_far_symbol);
               failures++;
            end
            if (rsp_cell_mask !== exp_res.cell_mask) begin
               $error("cell_mask expected %h actual %h", exp_res.cell_mask, rsp_cell_mask);
               failures++;
            end
         end
      end
   end

   initial begin
      #6000000;
      $display("** latin_square_hop_chain: FAILED **");
      $finish;
   end

   initial begin
      order_reg = ORDER_RESET;
      load_cyclic_square();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      gap_limit = 15;
      stall_limit = 15;
      test_reset_square();
      test_small_square();
      test_random_walks();
      test_backpressure();
      wait_drained();
      repeat (100) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("** latin_square_hop_chain: PASSED **");
      end else begin
         $display("** latin_square_hop_chain: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
